>>> src/mrpt_pkg.sv
// Shared constants, types and microcode ROM for the Miller-Rabin primality tester.
`default_nettype none

package mrpt_pkg;

  localparam int FIELD_W        = 62;   // width of the candidate and base fields
  localparam int CAND_WIDTH_DEF = 62;
  localparam int NUM_BASES      = 5;
  localparam int MAX_ROUNDS     = 5;
  localparam int RND_W          = 3;
  localparam int ROUNDS_W       = 3;
  localparam int RED_CNT_W      = $clog2(FIELD_W);
  localparam int PC_W           = 5;

  localparam logic [ROUNDS_W-1:0] ROUNDS_RST = 3'd5;
  localparam logic [RND_W-1:0] RND_LIMIT =
      RND_W'((MAX_ROUNDS < NUM_BASES) ? MAX_ROUNDS : NUM_BASES);

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_HALVE,
    OP_RED_START,
    OP_WB_BASE,
    OP_MUL_XB,
    OP_WB_X,
    OP_MUL_BB,
    OP_WB_B,
    OP_CHK_INIT,
    OP_SQ_X,
    OP_RND_INC,
    OP_SET_PRIME,
    OP_SET_COMP,
    OP_SET_SMALL,
    OP_EMIT
  } op_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NEVER,
    C_NO_IN,
    C_SMALL,
    C_S_EVEN,
    C_BUSY,
    C_E_ZERO,
    C_E_EVEN,
    C_I_DONE,
    C_FAIL,
    C_LAST,
    C_OUT_FULL
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } ucode_t;

  // status flags from the datapath to the sequencer
  typedef struct packed {
    logic no_in;
    logic small_cand;
    logic s_even;
    logic busy;
    logic e_zero;
    logic e_even;
    logic i_done;
    logic fail;
    logic last;
    logic out_full;
  } mrpt_stat_t;

  // microprogram addresses
  localparam logic [PC_W-1:0] A_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] A_CHKSM = 5'd1;
  localparam logic [PC_W-1:0] A_HALVE = 5'd2;
  localparam logic [PC_W-1:0] A_ROUND = 5'd3;
  localparam logic [PC_W-1:0] A_RWAIT = 5'd4;
  localparam logic [PC_W-1:0] A_POW   = 5'd5;
  localparam logic [PC_W-1:0] A_EBIT  = 5'd6;
  localparam logic [PC_W-1:0] A_MULXB = 5'd7;
  localparam logic [PC_W-1:0] A_WXB   = 5'd8;
  localparam logic [PC_W-1:0] A_SQB   = 5'd9;
  localparam logic [PC_W-1:0] A_WSQB  = 5'd10;
  localparam logic [PC_W-1:0] A_PNEXT = 5'd11;
  localparam logic [PC_W-1:0] A_CHK   = 5'd12;
  localparam logic [PC_W-1:0] A_CLOOP = 5'd13;
  localparam logic [PC_W-1:0] A_SQX   = 5'd14;
  localparam logic [PC_W-1:0] A_WSQX  = 5'd15;
  localparam logic [PC_W-1:0] A_CNEXT = 5'd16;
  localparam logic [PC_W-1:0] A_REND  = 5'd17;
  localparam logic [PC_W-1:0] A_RINC  = 5'd18;
  localparam logic [PC_W-1:0] A_RNEXT = 5'd19;
  localparam logic [PC_W-1:0] A_PRIME = 5'd20;
  localparam logic [PC_W-1:0] A_COMP  = 5'd21;
  localparam logic [PC_W-1:0] A_SMALL = 5'd22;
  localparam logic [PC_W-1:0] A_EMIT  = 5'd23;
  localparam logic [PC_W-1:0] A_DONE  = 5'd24;

  function automatic ucode_t uw(input op_e op, input cond_e cond,
                                input logic [PC_W-1:0] target);
    ucode_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // The op of a word executes, then the jump is taken if its condition holds.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    case (addr)
      A_IDLE:  w = uw(OP_LOAD,      C_NO_IN,    A_IDLE);
      A_CHKSM: w = uw(OP_NOP,       C_SMALL,    A_SMALL);
      A_HALVE: w = uw(OP_HALVE,     C_S_EVEN,   A_HALVE);
      A_ROUND: w = uw(OP_RED_START, C_NEVER,    A_IDLE);
      A_RWAIT: w = uw(OP_WB_BASE,   C_BUSY,     A_RWAIT);
      A_POW:   w = uw(OP_NOP,       C_E_ZERO,   A_CHK);
      A_EBIT:  w = uw(OP_NOP,       C_E_EVEN,   A_SQB);
      A_MULXB: w = uw(OP_MUL_XB,    C_NEVER,    A_IDLE);
      A_WXB:   w = uw(OP_WB_X,      C_BUSY,     A_WXB);
      A_SQB:   w = uw(OP_MUL_BB,    C_NEVER,    A_IDLE);
      A_WSQB:  w = uw(OP_WB_B,      C_BUSY,     A_WSQB);
      A_PNEXT: w = uw(OP_NOP,       C_ALWAYS,   A_POW);
      A_CHK:   w = uw(OP_CHK_INIT,  C_NEVER,    A_IDLE);
      A_CLOOP: w = uw(OP_NOP,       C_I_DONE,   A_REND);
      A_SQX:   w = uw(OP_SQ_X,      C_NEVER,    A_IDLE);
      A_WSQX:  w = uw(OP_WB_X,      C_BUSY,     A_WSQX);
      A_CNEXT: w = uw(OP_NOP,       C_ALWAYS,   A_CLOOP);
      A_REND:  w = uw(OP_NOP,       C_FAIL,     A_COMP);
      A_RINC:  w = uw(OP_RND_INC,   C_LAST,     A_PRIME);
      A_RNEXT: w = uw(OP_NOP,       C_ALWAYS,   A_ROUND);
      A_PRIME: w = uw(OP_SET_PRIME, C_ALWAYS,   A_EMIT);
      A_COMP:  w = uw(OP_SET_COMP,  C_ALWAYS,   A_EMIT);
      A_SMALL: w = uw(OP_SET_SMALL, C_NEVER,    A_IDLE);
      A_EMIT:  w = uw(OP_EMIT,      C_OUT_FULL, A_EMIT);
      A_DONE:  w = uw(OP_NOP,       C_ALWAYS,   A_IDLE);
      default: w = uw(OP_NOP,       C_ALWAYS,   A_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> src/mrpt_ifs.sv
// Valid/ready channel interfaces: candidate request, verdict, and rounds configuration.
`default_nettype none

interface mrpt_req_if;
  import mrpt_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] candidate;
  logic [FIELD_W-1:0] base_0;
  logic [FIELD_W-1:0] base_1;
  logic [FIELD_W-1:0] base_2;
  logic [FIELD_W-1:0] base_3;
  logic [FIELD_W-1:0] base_4;
  modport source (output valid, candidate, base_0, base_1, base_2, base_3, base_4,
                  input ready);
  modport sink   (input valid, candidate, base_0, base_1, base_2, base_3, base_4,
                  output ready);
endinterface

interface mrpt_res_if;
  logic valid;
  logic ready;
  logic is_prime;
  modport source (output valid, is_prime, input ready);
  modport sink   (input valid, is_prime, output ready);
endinterface

interface mrpt_cfg_if;
  import mrpt_pkg::*;
  logic                valid;
  logic                ready;
  logic [ROUNDS_W-1:0] rounds;
  modport source (output valid, rounds, input ready);
  modport sink   (input valid, rounds, output ready);
endinterface

`default_nettype wire

>>> src/mrpt_mulmod.sv
// Bit-serial modular unit: double-and-add multiply, or MSB-first reduction of a base.
`default_nettype none

module mrpt_mulmod #(
  parameter int W = mrpt_pkg::CAND_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic                         red_i,
  input  wire logic [W-1:0]                 a_i,
  input  wire logic [mrpt_pkg::FIELD_W-1:0] y_i,
  input  wire logic [W-1:0]                 m_i,
  output logic                              busy_o,
  output logic [W-1:0]                      res_o
);
  import mrpt_pkg::*;

  logic                 busy_q, busy_d, red_q;
  logic [W-1:0]         acc_q, acc_d, xx_q, xx_d, m_q;
  logic [FIELD_W-1:0]   y_q, y_d;
  logic [RED_CNT_W-1:0] cnt_q, cnt_d;
  logic [W:0]           sum, dbl, sh, mx;

  always_comb begin
    mx    = {1'b0, m_q};
    sum   = {1'b0, acc_q} + {1'b0, xx_q};
    dbl   = {xx_q, 1'b0};
    sh    = {acc_q, y_q[FIELD_W-1]};
    acc_d = acc_q;
    xx_d  = xx_q;
    y_d   = y_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      if (red_q) begin
        // remainder stays below m, so one conditional subtract per bit
        acc_d  = (sh >= mx) ? W'(sh - mx) : W'(sh);
        y_d    = y_q << 1;
        cnt_d  = cnt_q - 1'b1;
        busy_d = (cnt_q != '0);
      end else if (y_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (y_q[0]) begin
          acc_d = (sum >= mx) ? W'(sum - mx) : W'(sum);
        end
        xx_d = (dbl >= mx) ? W'(dbl - mx) : W'(dbl);
        y_d  = y_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      red_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      red_q  <= red_i;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      xx_q  <= a_i;
      y_q   <= y_i;
      m_q   <= m_i;
      cnt_q <= RED_CNT_W'(FIELD_W - 1);
    end else begin
      acc_q <= acc_d;
      xx_q  <= xx_d;
      y_q   <= y_d;
      cnt_q <= cnt_d;
    end
  end

  assign busy_o = busy_q;
  assign res_o  = acc_q;

endmodule

`default_nettype wire

>>> src/mrpt_dp.sv
// Datapath: operand registers, round bookkeeping, channel handshakes and the modular unit.
`default_nettype none

module mrpt_dp #(
  parameter int CAND_WIDTH = mrpt_pkg::CAND_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mrpt_pkg::op_e                 op_i,
  input  wire logic [mrpt_pkg::ROUNDS_W-1:0] rounds_i,
  mrpt_req_if.sink                           req_i,
  mrpt_res_if.source                         res_o,
  output mrpt_pkg::mrpt_stat_t               stat_o
);
  import mrpt_pkg::*;

  localparam int CW = $clog2(CAND_WIDTH);

  logic [CAND_WIDTH-1:0] p_q, pm1_q, s_q, e_q, x_q, b_q, cand;
  logic [CW-1:0]         twos_q, i_q;
  logic [RND_W-1:0]      rnd_q, cnt_q, cnt_d;
  logic [FIELD_W-1:0]    bases_q [NUM_BASES];
  logic                  pass_q, verdict_q, res_valid_q, res_prime_q;
  logic                  accept, emit_go;
  logic                  mm_start, mm_red, mm_busy;
  logic [CAND_WIDTH-1:0] mm_a, mm_res;
  logic [FIELD_W-1:0]    mm_y;

  assign cand    = req_i.candidate[CAND_WIDTH-1:0];
  assign accept  = req_i.valid && (op_i == OP_LOAD);
  assign emit_go = (op_i == OP_EMIT) && (!res_valid_q || res_o.ready);

  assign req_i.ready    = (op_i == OP_LOAD);
  assign res_o.valid    = res_valid_q;
  assign res_o.is_prime = res_prime_q;

  always_comb begin
    if (rounds_i == '0) begin
      cnt_d = RND_W'(1);
    end else if (rounds_i > RND_LIMIT) begin
      cnt_d = RND_LIMIT;
    end else begin
      cnt_d = rounds_i;
    end
  end

  always_comb begin
    mm_start = op_i inside {OP_RED_START, OP_MUL_XB, OP_MUL_BB, OP_SQ_X};
    mm_red   = (op_i == OP_RED_START);
    mm_a     = (op_i == OP_MUL_BB) ? b_q : x_q;
    case (op_i)
      OP_RED_START: mm_y = bases_q[rnd_q];
      OP_SQ_X:      mm_y = FIELD_W'(x_q);
      default:      mm_y = FIELD_W'(b_q);
    endcase
  end

  mrpt_mulmod #(
    .W (CAND_WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .red_i   (mm_red),
    .a_i     (mm_a),
    .y_i     (mm_y),
    .m_i     (p_q),
    .busy_o  (mm_busy),
    .res_o   (mm_res)
  );

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        if (req_i.valid) begin
          p_q        <= cand;
          pm1_q      <= cand - 1'b1;
          s_q        <= cand - 1'b1;
          twos_q     <= '0;
          rnd_q      <= '0;
          cnt_q      <= cnt_d;
          bases_q[0] <= req_i.base_0;
          bases_q[1] <= req_i.base_1;
          bases_q[2] <= req_i.base_2;
          bases_q[3] <= req_i.base_3;
          bases_q[4] <= req_i.base_4;
        end
      end
      OP_HALVE: begin
        if (!s_q[0]) begin
          s_q    <= s_q >> 1;
          twos_q <= twos_q + 1'b1;
        end
      end
      OP_WB_BASE: begin
        if (!mm_busy) begin
          b_q <= mm_res;
          x_q <= CAND_WIDTH'(1);
          e_q <= s_q;
        end
      end
      OP_MUL_BB: e_q <= e_q >> 1;
      OP_WB_X: begin
        if (!mm_busy) x_q <= mm_res;
      end
      OP_WB_B: begin
        if (!mm_busy) b_q <= mm_res;
      end
      OP_CHK_INIT: begin
        pass_q <= (x_q == CAND_WIDTH'(1));
        i_q    <= '0;
      end
      OP_SQ_X: begin
        if (x_q == pm1_q) pass_q <= 1'b1;
        i_q <= i_q + 1'b1;
      end
      OP_RND_INC:   rnd_q <= rnd_q + 1'b1;
      OP_SET_PRIME: verdict_q <= 1'b1;
      OP_SET_COMP:  verdict_q <= 1'b0;
      OP_SET_SMALL: begin
        verdict_q <= (p_q inside {CAND_WIDTH'(2), CAND_WIDTH'(3), CAND_WIDTH'(5)});
      end
      default: ;
    endcase
    if (emit_go) res_prime_q <= verdict_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (emit_go) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // accept is implied by no_in being low while the LOAD word is active
  always_comb begin
    stat_o.no_in      = !accept;
    stat_o.small_cand = (p_q <= CAND_WIDTH'(5));
    stat_o.s_even     = !s_q[0];
    stat_o.busy       = mm_busy;
    stat_o.e_zero     = (e_q == '0);
    stat_o.e_even     = !e_q[0];
    stat_o.i_done     = (i_q == twos_q);
    stat_o.fail       = !pass_q;
    stat_o.last       = (rnd_q == cnt_q - RND_W'(1));
    stat_o.out_full   = res_valid_q && !res_o.ready;
  end

endmodule

`default_nettype wire

>>> src/mrpt_seq.sv
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
`default_nettype none

module mrpt_seq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mrpt_pkg::mrpt_stat_t stat_i,
  output mrpt_pkg::op_e             op_o
);
  import mrpt_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          word;
  logic            taken;

  always_comb begin
    word = ucode_rom(pc_q);
    case (word.cond)
      C_ALWAYS:   taken = 1'b1;
      C_NEVER:    taken = 1'b0;
      C_NO_IN:    taken = stat_i.no_in;
      C_SMALL:    taken = stat_i.small_cand;
      C_S_EVEN:   taken = stat_i.s_even;
      C_BUSY:     taken = stat_i.busy;
      C_E_ZERO:   taken = stat_i.e_zero;
      C_E_EVEN:   taken = stat_i.e_even;
      C_I_DONE:   taken = stat_i.i_done;
      C_FAIL:     taken = stat_i.fail;
      C_LAST:     taken = stat_i.last;
      C_OUT_FULL: taken = stat_i.out_full;
      default:    taken = 1'b1;
    endcase
    pc_d = taken ? word.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= A_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o = word.op;

endmodule

`default_nettype wire

>>> src/miller_rabin_primality_test.sv
// Top level: rounds register, microcode sequencer and datapath of the primality tester.
//
// Miller-Rabin test of one candidate (low CAND_WIDTH bits of the field) against the
// first "rounds" of five witness bases; rounds is clamped to 1..5 and resets to 5.
// Candidates up to 5 are decided directly (2, 3, 5 prime). One transaction is
// worked at a time by a microcoded sequencer driving a single bit-serial modular
// unit, one operand bit per cycle. Per round: the base is reduced modulo the
// candidate, then for each exponent bit a squaring plus a multiply when the bit is
// set, then k squarings for the 2^k part of candidate-1. The verdict sits in an
// output register, so the next candidate is taken while it waits; configuration
// is always ready.
`default_nettype none

module miller_rabin_primality_test #(
  parameter int CAND_WIDTH = mrpt_pkg::CAND_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mrpt_req_if.sink   req_i,
  mrpt_res_if.source res_o,
  mrpt_cfg_if.sink   cfg_i
);
  import mrpt_pkg::*;

  logic [ROUNDS_W-1:0] rounds_q;
  op_e                 op;
  mrpt_stat_t          stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q <= ROUNDS_RST;
    end else if (cfg_i.valid) begin
      rounds_q <= cfg_i.rounds;
    end
  end

  mrpt_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .op_o   (op)
  );

  mrpt_dp #(
    .CAND_WIDTH (CAND_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .rounds_i (rounds_q),
    .req_i    (req_i),
    .res_o    (res_o),
    .stat_o   (stat)
  );

`ifndef SYNTHESIS
  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(op) == OP_EMIT)
    else $error("verdict valid rose without an emit step");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_RED_START || op == OP_MUL_XB || op == OP_MUL_BB || op == OP_SQ_X)
      |-> !stat.busy)
    else $error("modular unit started while busy");

  a_load_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> op != OP_LOAD)
    else $error("sequencer stayed in load after a transaction");
`endif

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Testbench for the Miller-Rabin primality tester: directed table, random candidates, scoreboard.
module tb_top;
  import mrpt_pkg::*;

  localparam int WD_LIMIT = 400000;   // cycles with no transaction before giving up
  localparam int DIR_ROWS = 23;
  localparam int PHASES   = 9;
  localparam int PHASE_N  = 9;

  localparam logic [FIELD_W-1:0] ONES = 62'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [FIELD_W-1:0] M61  = 62'h1FFF_FFFF_FFFF_FFFF;  // 2^61-1, prime
  localparam logic [FIELD_W-1:0] P62  = 62'h3FFF_FFFF_FFFF_FFC7;  // largest prime below 2^62

  typedef logic [0:NUM_BASES-1][FIELD_W-1:0] base_vec_t;

  typedef struct packed {
    logic [ROUNDS_W-1:0] rnd;
    logic [FIELD_W-1:0]  cand;
    base_vec_t           b;
    bit                  known;
    bit                  prime;
  } dir_row_t;

  typedef struct packed {
    logic [FIELD_W-1:0] cand;
    bit                 prime;
  } verdict_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // small candidates, decided without rounds
    '{3'd5, 62'd0, '{62'd7, 62'd7, 62'd7, 62'd7, 62'd7}, 1'b1, 1'b0},
    '{3'd5, 62'd1, '{62'd0, 62'd0, 62'd0, 62'd0, 62'd0}, 1'b1, 1'b0},
    '{3'd5, 62'd2, '{62'd0, 62'd0, 62'd0, 62'd0, 62'd0}, 1'b1, 1'b1},
    '{3'd5, 62'd3, '{ONES, ONES, ONES, ONES, ONES}, 1'b1, 1'b1},
    '{3'd5, 62'd4, '{62'd2, 62'd3, 62'd1, 62'd1, 62'd1}, 1'b1, 1'b0},
    '{3'd5, 62'd5, '{62'd5, 62'd0, 62'd5, 62'd0, 62'd5}, 1'b1, 1'b1},
    // even candidate, all bases 1: every round passes
    '{3'd5, 62'd6, '{62'd1, 62'd1, 62'd1, 62'd1, 62'd1}, 1'b1, 1'b1},
    '{3'd5, 62'd6, '{62'd2, 62'd3, 62'd5, 62'd7, 62'd11}, 1'b0, 1'b0},
    // a base that is a multiple of the candidate fails its round
    '{3'd5, 62'd7, '{62'd7, 62'd2, 62'd3, 62'd4, 62'd5}, 1'b1, 1'b0},
    '{3'd5, 62'd97, '{62'd2, 62'd3, 62'd5, 62'd7, 62'd291}, 1'b1, 1'b0},
    '{3'd5, 62'd97, '{ONES, ONES, ONES, ONES, ONES}, 1'b0, 1'b0},
    // rounds zero runs one round; 2047 is a strong pseudoprime to base 2
    '{3'd0, 62'd2047, '{62'd2, 62'd3, 62'd3, 62'd3, 62'd3}, 1'b0, 1'b0},
    // rounds above range saturate, so the fifth base is used
    '{3'd7, 62'd2047, '{62'd2, 62'd2, 62'd2, 62'd2, 62'd3}, 1'b0, 1'b0},
    '{3'd1, 62'd561, '{62'd2, 62'd1, 62'd1, 62'd1, 62'd1}, 1'b0, 1'b0},
    '{3'd6, 62'd561, '{62'd50, 62'd560, 62'd1, 62'd562, 62'd100}, 1'b0, 1'b0},
    '{3'd4, 62'd10, '{62'd9, 62'd1, 62'd1, 62'd1, 62'd1}, 1'b0, 1'b0},
    '{3'd3, ONES, '{ONES, ONES, ONES, ONES, ONES}, 1'b1, 1'b0},
    '{3'd5, M61, '{62'd2, 62'd3, 62'd5, 62'd7, M61 - 62'd1}, 1'b0, 1'b0},
    '{3'd2, P62, '{62'h2AAA_AAAA_AAAA_AAAA, 62'h1555_5555_5555_5555, 62'd0, 62'd0,
                   62'd0}, 1'b0, 1'b0},
    '{3'd5, 62'h2000_0000_0000_0001, '{62'd2, 62'd3, 62'd5, 62'd7, 62'd11}, 1'b0, 1'b0},
    '{3'd5, 62'd25326001, '{62'd2, 62'd3, 62'd5, 62'd7, 62'd11}, 1'b0, 1'b0},
    '{3'd5, 62'd3215031751, '{62'd2, 62'd3, 62'd5, 62'd7, 62'd11}, 1'b0, 1'b0},
    '{3'd5, 62'd8, '{62'd1, 62'd7, 62'd15, 62'd9, 62'd1}, 1'b0, 1'b0}
  };

  localparam logic [ROUNDS_W-1:0] PHASE_RND [PHASES] =
      '{3'd3, 3'd5, 3'd1, 3'd7, 3'd0, 3'd2, 3'd6, 3'd4, 3'd5};

  logic clk;
  logic rst_n;

  mrpt_req_if req_if ();
  mrpt_res_if res_if ();
  mrpt_cfg_if cfg_if ();

  miller_rabin_primality_test i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  verdict_t            verdict_q [$];
  logic [ROUNDS_W-1:0] rnd_cfg;
  bit                  quiet;
  int unsigned         n_err;
  int unsigned         idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // (a * b) mod m by doubling; a, b < m < 2^62 keeps every sum below 2^63
  function automatic logic [63:0] mulmod_add(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd0;
    while (b != 64'd0) begin
      if (b[0]) begin
        acc += a;
        if (acc >= m) acc -= m;
      end
      a += a;
      if (a >= m) a -= m;
      b >>= 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] expmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    while (e != 64'd0) begin
      if (e[0]) acc = mulmod_add(acc, b, m);
      b = mulmod_add(b, b, m);
      e >>= 1;
    end
    return acc;
  endfunction

  function automatic bit mr_verdict(logic [FIELD_W-1:0] cand, base_vec_t b,
                                    logic [ROUNDS_W-1:0] rnd);
    logic [63:0] p;
    logic [63:0] pm1;
    logic [63:0] odd;
    logic [63:0] x;
    int unsigned twos;
    int unsigned cnt;
    bit          pass;
    p   = {2'b00, cand};
    cnt = (rnd == '0) ? 1 : int'(rnd);
    if (cnt > MAX_ROUNDS) cnt = MAX_ROUNDS;
    if (cnt > NUM_BASES) cnt = NUM_BASES;
    if (p <= 64'd5) return (p == 64'd2) || (p == 64'd3) || (p == 64'd5);
    pm1  = p - 64'd1;
    odd  = pm1;
    twos = 0;
    while (!odd[0]) begin
      odd >>= 1;
      twos++;
    end
    for (int r = 0; r < cnt; r++) begin
      x    = expmod({2'b00, b[r]} % p, odd, p);
      pass = (x == 64'd1);
      for (int i = 0; i < twos; i++) begin
        if (x == pm1) pass = 1'b1;
        x = mulmod_add(x, x, p);
      end
      if (!pass) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_item(input logic [FIELD_W-1:0] cand, input base_vec_t b,
                           input bit known, input bit prime);
    verdict_t v;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.candidate <= cand;
    req_if.base_0    <= b[0];
    req_if.base_1    <= b[1];
    req_if.base_2    <= b[2];
    req_if.base_3    <= b[3];
    req_if.base_4    <= b[4];
    do @(posedge clk); while (!req_if.ready);
    v.cand  = cand;
    v.prime = known ? prime : mr_verdict(cand, b, rnd_cfg);
    verdict_q = {verdict_q, v};
    @(negedge clk);
  endtask

  // rounds may only change with nothing in flight
  task automatic set_rounds(input logic [ROUNDS_W-1:0] val);
    req_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    cfg_if.valid  <= 1'b1;
    cfg_if.rounds <= val;
    do @(posedge clk); while (!cfg_if.ready);
    rnd_cfg = val;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // result side: ready drops low in random bursts, except while quiet is set
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        res_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (res_if.valid && res_if.ready) begin
      if (verdict_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected verdict %0b", res_if.is_prime);
      end else if (res_if.is_prime !== verdict_q[0].prime) begin
        n_err++;
        if (n_err <= 10)
          $display("verdict mismatch: candidate %0d expected %0b actual %0b",
                   verdict_q[0].cand, verdict_q[0].prime, res_if.is_prime);
        void'(verdict_q.pop_front());
      end else begin
        void'(verdict_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WD_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [FIELD_W-1:0] cand;
    base_vec_t          b;
    logic [63:0]        c64;
    logic [63:0]        dv;
    bit                 isp;
    int unsigned        kind;
    int unsigned        w;
    int unsigned        sel;

    n_err            = 0;
    idle_cycles      = 0;
    quiet            = 1'b0;
    rnd_cfg          = ROUNDS_RST;
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.candidate = '0;
    req_if.base_0    = '0;
    req_if.base_1    = '0;
    req_if.base_2    = '0;
    req_if.base_3    = '0;
    req_if.base_4    = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.rounds    = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TAB[r].rnd != rnd_cfg) set_rounds(DIR_TAB[r].rnd);
      send_item(DIR_TAB[r].cand, DIR_TAB[r].b, DIR_TAB[r].known, DIR_TAB[r].prime);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      set_rounds(PHASE_RND[ph]);
      quiet = (ph == PHASES - 1) || ($urandom_range(0, 4) == 0);
      for (int n = 0; n < PHASE_N; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          // small prime: walk up odd numbers by trial division
          w   = $urandom_range(3, 20);
          c64 = ({32'd0, $urandom} & ((64'd1 << w) - 64'd1)) | (64'd1 << (w - 1)) | 64'd1;
          do begin
            isp = 1'b1;
            for (dv = 64'd3; dv * dv <= c64; dv += 64'd2)
              if (c64 % dv == 64'd0) isp = 1'b0;
            if (!isp) c64 += 64'd2;
          end while (!isp);
          cand = c64[FIELD_W-1:0];
        end else if (kind < 80) begin
          w    = $urandom_range(3, 24);
          cand = FIELD_W'({32'd0, $urandom} & ((64'd1 << w) - 64'd1));
        end else if (kind < 90) begin
          // full width is slow, so only a few of these
          cand = FIELD_W'({$urandom, $urandom});
        end else begin
          cand = FIELD_W'($urandom_range(0, 5));
        end
        for (int j = 0; j < NUM_BASES; j++) begin
          sel = $urandom_range(0, 9);
          if (sel == 0)      b[j] = 62'd1;
          else if (sel == 1) b[j] = cand - 62'd1;
          else if (sel == 2) b[j] = cand * FIELD_W'($urandom_range(0, 3));
          else               b[j] = FIELD_W'({$urandom, $urandom});
        end
        send_item(cand, b, 1'b0, 1'b0);
      end
    end

    req_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (n_err == 0 && verdict_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
src/mrpt_pkg.sv
src/mrpt_ifs.sv
src/mrpt_mulmod.sv
src/mrpt_dp.sv
src/mrpt_seq.sv
src/miller_rabin_primality_test.sv
dv/tb_top.sv
